// ===== hdl/tmta_pkg.sv =====
// Shared types and constants of the task mask time accounting unit.
`default_nettype none

package tmta_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_TIMER_PERIOD  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LOAD_TASK_BIT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [31:0] TIMER_PERIOD_RESET  = 32'd60000000;
  localparam logic [1:0]  LOAD_TASK_BIT_RESET = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_value;
    logic [1:0]  task_bit;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  bucket_index;
    logic [31:0] bucket_time;
    logic        last_bucket;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/task_mask_time_accounting_unit.sv =====
// Set, clear and unknown items and a first sample are handled on acceptance alone.
// A sample without wrap steps through accept, read/subtract and add/write.
// A wrap then reads and offers every bucket in turn, holding on output stalls, and
// restarts the totals; compare, subtract and add share one 32-bit adder.
// Reset clears mask, previous sample, per-bucket valid flags and state, and loads the
// register defaults; no clearing pass is needed and the block is ready right after reset.
`default_nettype none

module task_mask_time_accounting_unit
  import tmta_pkg::*;
#(
  parameter int unsigned MASK_BITS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int unsigned NumBuckets = 1 << MASK_BITS;

  state_e state_q, state_d;

  logic [31:0]          timer_period_q;
  logic [1:0]           load_task_bit_q;
  logic [MASK_BITS-1:0] mask_q, mask_d;
  logic [31:0]          prev_q, prev_d;
  logic [31:0]          sample_q, sample_d;
  logic                 wrap_q, wrap_d;
  logic [31:0]          addend_q, addend_d;
  logic [MASK_BITS-1:0] idx_q, idx_d;
  logic [NumBuckets-1:0] valid_q, valid_d;

  // Bucket memory with registered read.
  logic [31:0]          mem_q [NumBuckets];
  logic [31:0]          rd_data_q;
  logic                 rd_ok_q;
  logic                 rd_en;
  logic [MASK_BITS-1:0] rd_addr;
  logic                 mem_we;
  logic [31:0]          wr_data;

  // Shared adder/subtractor.
  logic [31:0] op_a, op_b;
  logic        op_sub;
  logic [32:0] sum;
  logic [31:0] rd_total;

  logic in_fire, out_fire, last_idx;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign last_idx = (idx_q == {MASK_BITS{1'b1}});
  assign rd_total = rd_ok_q ? rd_data_q : 32'd0;

  // One adder serves the wrap compare, the elapsed-time subtract and the total update.
  assign sum = {1'b0, op_a} + {1'b0, op_b ^ {32{op_sub}}} + {32'd0, op_sub};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_item_i.kind == KIND_SAMPLE && prev_q != 32'd0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = wrap_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready_i) begin
          state_d = last_idx ? ST_FINISH : ST_EMIT_RD;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs: handshakes, memory controls and adder operand selection.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    mem_we      = 1'b0;
    wr_data     = sum[31:0];
    op_a        = in_item_i.timer_value;
    op_b        = prev_q;
    op_sub      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = mask_q;
        op_a    = wrap_q ? timer_period_q : sample_q;
      end
      ST_ADD: begin
        mem_we = 1'b1;
        op_a   = rd_total;
        op_b   = addend_q;
        op_sub = 1'b0;
      end
      ST_EMIT_RD: begin
        rd_en = 1'b1;
      end
      ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
      end
      ST_FINISH: begin
        mem_we  = 1'b1;
        wr_data = sample_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    mask_d   = mask_q;
    prev_d   = prev_q;
    sample_d = sample_q;
    wrap_d   = wrap_q;
    addend_d = addend_q;
    idx_d    = idx_q;
    valid_d  = valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.kind)
            KIND_SAMPLE: begin
              sample_d = in_item_i.timer_value;
              if (prev_q == 32'd0) begin
                prev_d = in_item_i.timer_value;
              end else begin
                // A borrow out of sample - previous marks a timer wrap.
                wrap_d = !sum[32];
                if (!sum[32]) begin
                  for (int j = 0; j < MASK_BITS; j++) begin
                    if (32'(load_task_bit_q) == j) begin
                      mask_d[j] = 1'b1;
                    end
                  end
                end
              end
            end
            KIND_SET: begin
              for (int j = 0; j < MASK_BITS; j++) begin
                if (32'(in_item_i.task_bit) == j) begin
                  mask_d[j] = 1'b1;
                end
              end
            end
            KIND_CLEAR: begin
              mask_d = '0;
            end
            default: begin
              mask_d = mask_q;
            end
          endcase
        end
      end
      ST_READ: begin
        // A period at or below the previous sample leaves no remainder.
        addend_d = (wrap_q && !sum[32]) ? 32'd0 : sum[31:0];
      end
      ST_ADD: begin
        valid_d[mask_q] = 1'b1;
        idx_d           = '0;
        if (!wrap_q) begin
          prev_d = sample_q;
        end
      end
      ST_EMIT_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        valid_d         = '0;
        valid_d[mask_q] = 1'b1;
        prev_d          = sample_q;
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      timer_period_q  <= TIMER_PERIOD_RESET;
      load_task_bit_q <= LOAD_TASK_BIT_RESET;
      mask_q          <= '0;
      prev_q          <= 32'd0;
      wrap_q          <= 1'b0;
      idx_q           <= '0;
      valid_q         <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      prev_q  <= prev_d;
      wrap_q  <= wrap_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TIMER_PERIOD:  timer_period_q  <= cfg_data_i;
          REG_LOAD_TASK_BIT: load_task_bit_q <= cfg_data_i[1:0];
          default:           timer_period_q  <= timer_period_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    addend_q <= addend_d;
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mask_q] <= wr_data;
    end
  end

  // Memory read port; the valid flag travels with the read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_ok_q   <= valid_q[rd_addr];
    end
  end

  // Result transaction fields.
  logic [MASK_BITS+3:0] idx_wide;
  assign idx_wide                = (MASK_BITS+4)'(idx_q);
  assign out_item_o.bucket_index = idx_wide[3:0];
  assign out_item_o.bucket_time  = rd_total;
  assign out_item_o.last_bucket  = last_idx;

`ifndef SYNTHESIS
  // Input and output never handshake in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input ready while a bucket is offered");

  // After a run, only the current mask's bucket holds a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> $onehot(valid_q))
    else $error("bucket valid flags not reset after a run");

  // The final bucket of a run leads to the restart of the totals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_item_o.last_bucket |=> state_q == ST_FINISH)
    else $error("run ended without restarting totals");

  // Buckets are reported in consecutive index order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_item_o.last_bucket |=> idx_q == $past(idx_q) + 1'b1)
    else $error("bucket index skipped");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the task mask time accounting unit.
`timescale 1ns / 100ps

module testbench
  import tmta_pkg::*;
();

  localparam int unsigned MASK_BITS        = 4;
  localparam int unsigned NUM_BUCKETS      = 1 << MASK_BITS;
  localparam logic [1:0]  KIND_UNKNOWN     = 2'd3;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned END_CYCLES       = 50;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned PHASE_ITEMS      = 108;

  // Clock, reset and block inputs, all known from time zero.
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_item_t           in_item   = '0;
  logic               out_ready = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data  = '0;
  logic               in_ready;
  logic               out_valid;
  out_item_t          out_item;

  // Transactions waiting to be offered, and bucket reports still to come.
  in_item_t  pending_items[$];
  out_item_t expected_buckets[$];

  // Accounting state as predicted from the accepted transactions.
  logic [31:0]          model_totals[NUM_BUCKETS];
  logic [MASK_BITS-1:0] model_mask   = '0;
  logic [31:0]          model_prev   = '0;
  logic [31:0]          model_period = TIMER_PERIOD_RESET;
  logic [1:0]           model_load_bit = LOAD_TASK_BIT_RESET;

  // Run controls shared between the stimulus and the two channel processes.
  logic        sender_gaps_on   = 1'b1;
  logic        receiver_stalls_on = 1'b1;
  logic        long_hold_armed  = 1'b0;
  logic [31:0] sample_track     = '0;
  int          gap_left         = 0;
  int          stall_left       = 0;
  int unsigned cycle_count      = 0;
  int unsigned items_accepted   = 0;
  int unsigned wraps_predicted  = 0;
  int unsigned reports_checked  = 0;
  int unsigned mismatches       = 0;

  task_mask_time_accounting_unit #(
    .MASK_BITS(MASK_BITS)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Global watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d reports outstanding", $time,
               expected_buckets.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Update the accounting state for one accepted transaction and queue the
  // bucket reports that a timer wrap releases.
  task automatic account_item(input in_item_t item);
    logic [31:0] rest;
    out_item_t   report;
    case (item.kind)
      KIND_SET: model_mask = model_mask | MASK_BITS'(1 << item.task_bit);
      KIND_CLEAR: model_mask = '0;
      KIND_SAMPLE: begin
        // With no previous sample the value is only stored.
        if (model_prev != '0) begin
          if (item.timer_value < model_prev) begin
            model_mask = model_mask | MASK_BITS'(1 << model_load_bit);
            rest = (model_period > model_prev) ? model_period - model_prev : '0;
            model_totals[model_mask] += rest;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
              report.bucket_index = 4'(i);
              report.bucket_time  = model_totals[i];
              report.last_bucket  = (i == NUM_BUCKETS - 1);
              expected_buckets.push_back(report);
            end
            for (int i = 0; i < NUM_BUCKETS; i++) model_totals[i] = '0;
            model_totals[model_mask] = item.timer_value;
            wraps_predicted++;
          end else begin
            model_totals[model_mask] += item.timer_value - model_prev;
          end
        end
        model_prev = item.timer_value;
      end
      default: ;
    endcase
  endtask

  // Compare one accepted bucket report with the oldest expectation.
  task automatic check_bucket(input out_item_t got);
    out_item_t want;
    if (expected_buckets.size() == 0) begin
      $display("%0t: unexpected report: expected none, got index %0d time %0d last %0b",
               $time, got.bucket_index, got.bucket_time, got.last_bucket);
      mismatches++;
    end else begin
      want = expected_buckets.pop_front();
      reports_checked++;
      if (got.bucket_index !== want.bucket_index) begin
        $display("%0t: bucket_index expected %0d, got %0d", $time,
                 want.bucket_index, got.bucket_index);
        mismatches++;
      end
      if (got.bucket_time !== want.bucket_time) begin
        $display("%0t: bucket_time of bucket %0d expected %0d, got %0d", $time,
                 want.bucket_index, want.bucket_time, got.bucket_time);
        mismatches++;
      end
      if (got.last_bucket !== want.last_bucket) begin
        $display("%0t: last_bucket of bucket %0d expected %0b, got %0b", $time,
                 want.bucket_index, want.last_bucket, got.last_bucket);
        mismatches++;
      end
    end
  endtask

  // Input driver: offers queued transactions, with a random gap after each one while gaps are on.
  always @(posedge clk or negedge rst_n) begin : input_driver
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && in_ready) begin
      account_item(in_item);
      items_accepted++;
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap == 0 && pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap_left <= gap;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= pending_items.pop_front();
      end
    end
  end

  // Output monitor: checks every report, stalls at random while stalls are on, and once for long when armed.
  always @(posedge clk or negedge rst_n) begin : output_monitor
    int stall;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_bucket(out_item);
      if (long_hold_armed && out_valid) begin
        long_hold_armed = 1'b0;
        out_ready  <= 1'b0;
        stall_left <= LONG_HOLD_CYCLES;
      end else if (out_valid && out_ready) begin
        stall = receiver_stalls_on ? $urandom_range(0, 6) : 0;
        out_ready  <= (stall == 0);
        stall_left <= stall;
      end else if (stall_left > 0) begin
        out_ready  <= (stall_left == 1);
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Write one configuration register and track it in the prediction.
  task automatic write_register(input logic [CfgIdxW-1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_TIMER_PERIOD:  model_period   = value;
      REG_LOAD_TASK_BIT: model_load_bit = value[1:0];
      default: ;
    endcase
  endtask

  // Queue one transaction; fields that the kind ignores are random.
  task automatic queue_item(input logic [1:0] kind, input logic [31:0] value,
                            input logic [1:0] task_bit);
    in_item_t item;
    item.kind        = kind;
    item.timer_value = (kind == KIND_SAMPLE) ? value : $urandom;
    item.task_bit    = (kind == KIND_SET) ? task_bit : 2'($urandom_range(0, 3));
    pending_items.push_back(item);
  endtask

  // Mostly rising samples with occasional wraps, mixed with task events and
  // some raw noise. Ignored kinds do not count toward the total.
  task automatic queue_random_items(input int count, input int unsigned max_step);
    in_item_t    item;
    int unsigned pick;
    int          made;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      item.timer_value = $urandom;
      item.task_bit    = 2'($urandom_range(0, 3));
      if (pick < 10) begin
        item.kind = KIND_SET;
      end else if (pick < 15) begin
        item.kind = KIND_CLEAR;
      end else if (pick < 18) begin
        item.kind = KIND_UNKNOWN;
      end else begin
        item.kind = KIND_SAMPLE;
        if (pick >= 22) begin
          if (pick < 28 && sample_track != '0)
            item.timer_value = $urandom_range(0, sample_track - 1);
          else
            item.timer_value = sample_track + $urandom_range(0, max_step);
        end
        sample_track = item.timer_value;
      end
      pending_items.push_back(item);
      if (item.kind != KIND_UNKNOWN) made++;
    end
  endtask

  // Wait until every transaction is taken and every report has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_buckets.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus: directed sequence at reset settings, then random phases.
  initial begin
    for (int i = 0; i < NUM_BUCKETS; i++) model_totals[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero and first samples are only stored, then equal samples, the
    // ignored kind, a wrap from beyond the period and a wrap to zero.
    queue_item(KIND_SAMPLE, 32'd0, 2'd0);
    queue_item(KIND_SAMPLE, 32'd100, 2'd0);
    queue_item(KIND_SET, '0, 2'd0);
    queue_item(KIND_SAMPLE, 32'd150, 2'd0);
    queue_item(KIND_SAMPLE, 32'd150, 2'd0);
    queue_item(KIND_UNKNOWN, '0, 2'd0);
    queue_item(KIND_SET, '0, 2'd3);
    queue_item(KIND_SET, '0, 2'd2);
    queue_item(KIND_SET, '0, 2'd1);
    queue_item(KIND_SAMPLE, 32'hFFFF_FFFF, 2'd0);
    queue_item(KIND_SAMPLE, 32'd200, 2'd0);
    queue_item(KIND_CLEAR, '0, 2'd0);
    queue_item(KIND_SAMPLE, 32'd300, 2'd0);
    queue_item(KIND_SAMPLE, 32'd59_999_990, 2'd0);
    queue_item(KIND_SAMPLE, 32'd5, 2'd0);
    queue_item(KIND_SAMPLE, 32'd0, 2'd0);
    queue_item(KIND_SAMPLE, 32'd7, 2'd0);
    queue_item(KIND_SET, '0, 2'd3);
    queue_item(KIND_SAMPLE, 32'd8, 2'd0);
    sample_track = 32'd8;
    wait_drained();

    // Shortest period with the highest load bit.
    write_register(REG_TIMER_PERIOD, 32'd1);
    write_register(REG_LOAD_TASK_BIT, 32'd3);
    queue_random_items(PHASE_ITEMS, 1000);
    wait_drained();

    // Longest period with large steps.
    write_register(REG_TIMER_PERIOD, 32'hFFFF_FFFF);
    write_register(REG_LOAD_TASK_BIT, 32'd2);
    queue_random_items(PHASE_ITEMS, 32'h0FFF_FFFF);
    wait_drained();

    // Mid-range period; the receiver holds off once for a long stretch.
    write_register(REG_TIMER_PERIOD, $urandom_range(32'h1_0000, 32'h40_0000));
    write_register(REG_LOAD_TASK_BIT, 32'd1);
    long_hold_armed = 1'b1;
    queue_random_items(PHASE_ITEMS, 50000);
    wait_drained();

    // Back to reset settings at full rate with no idling on either side.
    write_register(REG_TIMER_PERIOD, TIMER_PERIOD_RESET);
    write_register(REG_LOAD_TASK_BIT, 32'(LOAD_TASK_BIT_RESET));
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    queue_random_items(PHASE_ITEMS, 32'h000F_FFFF);
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    if (expected_buckets.size() != 0) begin
      $display("%0t: %0d bucket reports never arrived", $time, expected_buckets.size());
      mismatches++;
    end
    $display("Run covered %0d transactions over five register settings and %0d wraps.",
             items_accepted, wraps_predicted);
    $display("Bucket reports checked: %0d, mismatches: %0d.", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
